FILE: rtl/vvs_pkg.sv
// ----------------------------------------------------------------------------
// vvs_pkg
// Shared types and constants for the ventilator valve sequencer: the breathing
// phase encoding, motor command codes, register indexes and the bundles that
// pass between the top level and the sequencing core.
// ----------------------------------------------------------------------------
package vvs_pkg;

   // Default knob converter resolution.
   localparam int unsigned KNOB_BITS_DEFAULT = 10;

   // Period and setting widths.
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned SECONDS_W = 4;
   localparam int unsigned COUNT_W   = 4;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PERIOD   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MID_PERIOD    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_PERIOD  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_PERIOD = 2'd3;

   // Register reset values.
   localparam logic [PERIOD_W-1:0] LONG_PERIOD_RESET   = 16'd1000;
   localparam logic [PERIOD_W-1:0] MID_PERIOD_RESET    = 16'd250;
   localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RESET  = 16'd100;
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 16'd10;

   // Motor command codes.
   localparam logic [1:0] MOTOR_STOP  = 2'd0;
   localparam logic [1:0] MOTOR_START = 2'd2;

   // Fixed phase lengths, in period counts, for the open, hold and pause phases.
   localparam logic [COUNT_W-1:0] FIXED_COUNTS = 4'd2;

   // Width of the packed response data.
   localparam int unsigned RSP_BITS  = 19;
   localparam int unsigned RSP_TDATA_W = 24;

   typedef enum logic [2:0] {
      PH_OPEN    = 3'd0,
      PH_PRESS   = 3'd1,
      PH_HOLD    = 3'd2,
      PH_PAUSE_A = 3'd3,
      PH_RELIEF  = 3'd4,
      PH_PAUSE_B = 3'd5
   } vvs_phase_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] sample_period;
      logic [PERIOD_W-1:0] short_period;
      logic [PERIOD_W-1:0] mid_period;
      logic [PERIOD_W-1:0] long_period;
   } vvs_cfg_type;

   // Packed from the lowest bit up: pressure_valve first, phase_now last.
   typedef struct packed {
      vvs_phase_type        phase_now;
      logic                 running;
      logic                 relief_changed;
      logic                 press_changed;
      logic [SECONDS_W-1:0] relief_seconds;
      logic [SECONDS_W-1:0] press_seconds;
      logic [1:0]           motor_code;
      logic                 motor_strobe;
      logic                 relief_valve;
      logic                 pressure_valve;
   } vvs_rsp_type;

endpackage

FILE: rtl/vvs_core.sv
// ----------------------------------------------------------------------------
// vvs_core
// Per-tick sequencing state: button edge detection, knob sampling and the
// six-phase valve cycle. State advances once for each tick handed in.
// ----------------------------------------------------------------------------
module vvs_core #(
   parameter int unsigned KNOB_BITS = vvs_pkg::KNOB_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  button_down,
   input  logic [KNOB_BITS-1:0]  press_knob,
   input  logic [KNOB_BITS-1:0]  relief_knob,
   input  vvs_pkg::vvs_cfg_type  cfg,
   output vvs_pkg::vvs_rsp_type  rsp
);

   localparam int unsigned KnobFull = (1 << KNOB_BITS) - 1;
   localparam int unsigned K8W      = KNOB_BITS + 3;

   // Maps a knob sample to k*8/full + 2 by comparing 8k with each multiple of
   // the full-scale value.
   function automatic logic [vvs_pkg::SECONDS_W-1:0] knob_to_seconds(
      input logic [KNOB_BITS-1:0] k
   );
      logic [K8W-1:0]                k8;
      logic [vvs_pkg::SECONDS_W-1:0] q;
      k8 = {k, 3'b000};
      q  = 4'd2;
      for (int j = 1; j <= 8; j++) begin
         if (k8 >= K8W'(j * KnobFull)) begin
            q = q + 4'd1;
         end
      end
      return q;
   endfunction

   logic                            run_ff, run_in;
   logic                            latch_ff, latch_in;
   vvs_pkg::vvs_phase_type          phase_ff, phase_in;
   logic [vvs_pkg::COUNT_W-1:0]     counts_ff, counts_in;
   logic [vvs_pkg::PERIOD_W-1:0]    ticks_ff, ticks_in;
   logic [vvs_pkg::PERIOD_W-1:0]    sample_ff, sample_in;
   logic [KNOB_BITS-1:0]            prev_press_ff, prev_press_in;
   logic [KNOB_BITS-1:0]            prev_relief_ff, prev_relief_in;
   logic [vvs_pkg::SECONDS_W-1:0]   press_ff, press_in;
   logic [vvs_pkg::SECONDS_W-1:0]   relief_ff, relief_in;
   logic                            pressure_ff, pressure_in;
   logic                            relief_vlv_ff, relief_vlv_in;

   logic                            sample_fire;
   logic [vvs_pkg::PERIOD_W-1:0]    sample_next;
   logic [vvs_pkg::PERIOD_W-1:0]    ticks_next;
   logic                            press_chg, relief_chg;
   logic                            active, done;
   logic [vvs_pkg::PERIOD_W-1:0]    period;
   logic [vvs_pkg::COUNT_W-1:0]     target;
   logic                            strobe;
   logic [1:0]                      code;

   // Button, knob sampling and settings.
   always_comb begin
      run_in      = run_ff ^ (button_down & ~latch_ff);
      latch_in    = button_down;
      sample_next = sample_ff + 16'd1;
      sample_fire = (sample_next >= cfg.sample_period) || (sample_next == '0);
      sample_in   = sample_fire ? '0 : sample_next;
      press_chg   = sample_fire && (press_knob != prev_press_ff);
      relief_chg  = sample_fire && (relief_knob != prev_relief_ff);
      press_in    = press_chg ? knob_to_seconds(press_knob) : press_ff;
      relief_in   = relief_chg ? knob_to_seconds(relief_knob) : relief_ff;
      prev_press_in  = sample_fire ? press_knob : prev_press_ff;
      prev_relief_in = sample_fire ? relief_knob : prev_relief_ff;
      active      = run_in && (press_in != '0) && (relief_in != '0);
   end

   // Period and target of the current phase.
   always_comb begin
      unique case (phase_ff)
         vvs_pkg::PH_OPEN: begin
            period = cfg.mid_period;
            target = vvs_pkg::FIXED_COUNTS;
         end
         vvs_pkg::PH_PRESS: begin
            period = cfg.long_period;
            target = press_in;
         end
         vvs_pkg::PH_HOLD: begin
            period = cfg.mid_period;
            target = vvs_pkg::FIXED_COUNTS;
         end
         vvs_pkg::PH_PAUSE_A: begin
            period = cfg.short_period;
            target = vvs_pkg::FIXED_COUNTS;
         end
         vvs_pkg::PH_RELIEF: begin
            period = cfg.long_period;
            target = relief_in;
         end
         vvs_pkg::PH_PAUSE_B: begin
            period = cfg.short_period;
            target = vvs_pkg::FIXED_COUNTS;
         end
         default: begin
            period = 16'd1;
            target = '0;
         end
      endcase
      done       = counts_ff >= target;
      ticks_next = ticks_ff + 16'd1;
   end

   // Next phase and phase timing.
   always_comb begin
      phase_in  = phase_ff;
      counts_in = counts_ff;
      ticks_in  = ticks_ff;
      if (active) begin
         if (done) begin
            counts_in = '0;
            ticks_in  = '0;
            unique case (phase_ff)
               vvs_pkg::PH_OPEN:    phase_in = vvs_pkg::PH_PRESS;
               vvs_pkg::PH_PRESS:   phase_in = vvs_pkg::PH_HOLD;
               vvs_pkg::PH_HOLD:    phase_in = vvs_pkg::PH_PAUSE_A;
               vvs_pkg::PH_PAUSE_A: phase_in = vvs_pkg::PH_RELIEF;
               vvs_pkg::PH_RELIEF:  phase_in = vvs_pkg::PH_PAUSE_B;
               default:             phase_in = vvs_pkg::PH_OPEN;
            endcase
         end else if ((ticks_next >= period) || (ticks_next == '0)) begin
            ticks_in = '0;
            if (counts_ff != '1) begin
               counts_in = counts_ff + 4'd1;
            end
         end else begin
            ticks_in = ticks_next;
         end
      end
   end

   // Valve drives and motor commands.
   always_comb begin
      pressure_in   = pressure_ff;
      relief_vlv_in = relief_vlv_ff;
      strobe        = 1'b0;
      code          = vvs_pkg::MOTOR_STOP;
      if (active) begin
         if (phase_ff == vvs_pkg::PH_OPEN) begin
            pressure_in = 1'b1;
         end
         if (done) begin
            unique case (phase_ff)
               vvs_pkg::PH_OPEN: begin
                  strobe = 1'b1;
                  code   = vvs_pkg::MOTOR_START;
               end
               vvs_pkg::PH_PRESS: begin
                  strobe = 1'b1;
                  code   = vvs_pkg::MOTOR_STOP;
               end
               vvs_pkg::PH_HOLD:    pressure_in   = 1'b0;
               vvs_pkg::PH_PAUSE_A: relief_vlv_in = 1'b1;
               vvs_pkg::PH_RELIEF:  relief_vlv_in = 1'b0;
               default: begin
                  strobe = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp.pressure_valve = pressure_in;
      rsp.relief_valve   = relief_vlv_in;
      rsp.motor_strobe   = strobe;
      rsp.motor_code     = code;
      rsp.press_seconds  = press_in;
      rsp.relief_seconds = relief_in;
      rsp.press_changed  = press_chg;
      rsp.relief_changed = relief_chg;
      rsp.running        = run_in;
      rsp.phase_now      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff         <= 1'b0;
         latch_ff       <= 1'b0;
         phase_ff       <= vvs_pkg::PH_OPEN;
         counts_ff      <= '0;
         ticks_ff       <= '0;
         sample_ff      <= '0;
         prev_press_ff  <= '0;
         prev_relief_ff <= '0;
         press_ff       <= '0;
         relief_ff      <= '0;
         pressure_ff    <= 1'b0;
         relief_vlv_ff  <= 1'b0;
      end else if (advance) begin
         run_ff         <= run_in;
         latch_ff       <= latch_in;
         phase_ff       <= phase_in;
         counts_ff      <= counts_in;
         ticks_ff       <= ticks_in;
         sample_ff      <= sample_in;
         prev_press_ff  <= prev_press_in;
         prev_relief_ff <= prev_relief_in;
         press_ff       <= press_in;
         relief_ff      <= relief_in;
         pressure_ff    <= pressure_in;
         relief_vlv_ff  <= relief_vlv_in;
      end
   end

   // A motor command only goes out on leaving the open or pressurise phase.
   assert property (@(posedge clock) disable iff (reset)
      (advance && strobe) |=>
         (phase_ff == vvs_pkg::PH_PRESS || phase_ff == vvs_pkg::PH_HOLD))
      else $error("motor command without the matching phase change");

   // While stopped the cycle stays frozen.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !run_in) |=> ($stable(phase_ff) && $stable(counts_ff)))
      else $error("phase moved while stopped");

   // The two valves are never open together.
   assert property (@(posedge clock) disable iff (reset)
      !(pressure_ff && relief_vlv_ff))
      else $error("pressure and relief valves open together");

   // A freshly mapped setting lies between two and ten seconds.
   assert property (@(posedge clock) disable iff (reset)
      (advance && press_chg) |=> (press_ff >= 4'd2 && press_ff <= 4'd10))
      else $error("pressurise setting out of range");

endmodule

FILE: rtl/ventilator_valve_sequencer.sv
// ----------------------------------------------------------------------------
// ventilator_valve_sequencer
// Millisecond-tick valve sequencer for a ventilator: one request per tick,
// one response per request carrying valve drives, motor commands and status.
// ----------------------------------------------------------------------------
// Path: a request accepted into the input register moves through the core
// into the response register once that register is empty or being emptied.
// Throughput: one request per clock cycle while rsp_tready is high; the input
// and response registers each take one whenever the stage after them frees.
// Reset: synchronous and active high; it empties both stages, returns the
// cycle to the stopped open phase with valves closed and reloads the periods.
module ventilator_valve_sequencer #(
   parameter int unsigned KNOB_BITS = vvs_pkg::KNOB_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   // Request channel: one tick of button and knob samples.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // From bit 0: button_down, press_knob, relief_knob, zero fill.
   input  logic [((1 + 2 * KNOB_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   // Response channel: one result per request.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // From bit 0: pressure_valve, relief_valve, motor_strobe, motor_code,
   // press_seconds, relief_seconds, press_changed, relief_changed, running,
   // phase_now, zero fill.
   output logic [vvs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,

   // Configuration write port.
   input  logic                             csr_we,
   input  logic [vvs_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [vvs_pkg::PERIOD_W-1:0]     csr_wdata
);

   // Configuration registers.
   vvs_pkg::vvs_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_period   <= vvs_pkg::LONG_PERIOD_RESET;
         cfg_ff.mid_period    <= vvs_pkg::MID_PERIOD_RESET;
         cfg_ff.short_period  <= vvs_pkg::SHORT_PERIOD_RESET;
         cfg_ff.sample_period <= vvs_pkg::SAMPLE_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            vvs_pkg::CSR_LONG_PERIOD:   cfg_ff.long_period   <= csr_wdata;
            vvs_pkg::CSR_MID_PERIOD:    cfg_ff.mid_period    <= csr_wdata;
            vvs_pkg::CSR_SHORT_PERIOD:  cfg_ff.short_period  <= csr_wdata;
            vvs_pkg::CSR_SAMPLE_PERIOD: cfg_ff.sample_period <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input stage. A request moves on to the core whenever the response
   // register is empty or is being emptied in the same cycle, so the request
   // side keeps taking a request every cycle while the response side flows.
   logic                  in_valid_ff;
   logic                  in_btn_ff;
   logic [KNOB_BITS-1:0]  in_press_ff;
   logic [KNOB_BITS-1:0]  in_relief_ff;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic                  req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_btn_ff    <= req_tdata[0];
         in_press_ff  <= req_tdata[KNOB_BITS:1];
         in_relief_ff <= req_tdata[2*KNOB_BITS:KNOB_BITS+1];
      end
   end

   // Sequencing core: its state steps once per request handed over, and the
   // response it forms is captured in the response register on that edge.
   vvs_pkg::vvs_rsp_type core_rsp;

   vvs_core #(
      .KNOB_BITS (KNOB_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .button_down (in_btn_ff),
      .press_knob  (in_press_ff),
      .relief_knob (in_relief_ff),
      .cfg         (cfg_ff),
      .rsp         (core_rsp)
   );

   // Response register.
   vvs_pkg::vvs_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(vvs_pkg::RSP_TDATA_W - vvs_pkg::RSP_BITS)'(0), rsp_data_ff};

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Ventilator valve sequencer testbench
// Drives millisecond tick requests with bursty pacing, stalls the response
// side on a rotating pattern and checks every response field against a
// tick-by-tick prediction of the breathing sequence, held in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned KNOB_FULL   = (1 << vvs_pkg::KNOB_BITS_DEFAULT) - 1;

   // Every input of the block has a known value from time zero onwards.
   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // From bit 0: button_down, press_knob, relief_knob, zero fill.
   logic [REQ_TDATA_W-1:0]            req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // From bit 0: pressure_valve, relief_valve, motor_strobe, motor_code,
   // press_seconds, relief_seconds, press_changed, relief_changed, running,
   // phase_now, zero fill.
   logic [vvs_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [vvs_pkg::CSR_ADDR_W-1:0]    csr_addr   = vvs_pkg::CSR_LONG_PERIOD;
   logic [vvs_pkg::PERIOD_W-1:0]      csr_wdata  = '0;

   ventilator_valve_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // The scoreboard keeps its own copy of the sequencer state and registers.
   // Each accepted request advances that copy by one tick and queues the
   // response it should produce; each accepted response is checked against
   // the oldest queued one.
   // -------------------------------------------------------------------------
   class valve_scoreboard;
      bit [15:0]              long_per   = vvs_pkg::LONG_PERIOD_RESET;
      bit [15:0]              mid_per    = vvs_pkg::MID_PERIOD_RESET;
      bit [15:0]              short_per  = vvs_pkg::SHORT_PERIOD_RESET;
      bit [15:0]              sample_per = vvs_pkg::SAMPLE_PERIOD_RESET;
      bit                     run_flag   = 1'b0;
      bit                     btn_latch  = 1'b0;
      vvs_pkg::vvs_phase_type phase      = vvs_pkg::PH_OPEN;
      bit [3:0]               counts     = '0;
      bit [15:0]              period_ticks = '0;
      bit [15:0]              sample_ticks = '0;
      bit [9:0]               prev_pk    = '0;
      bit [9:0]               prev_rk    = '0;
      bit [3:0]               press_s    = '0;
      bit [3:0]               relief_s   = '0;
      bit                     press_open = 1'b0;
      bit                     relief_open = 1'b0;
      vvs_pkg::vvs_rsp_type   expected_q[$];
      int unsigned            mismatches = 0;
      int unsigned            responses  = 0;

      function void write_register(logic [vvs_pkg::CSR_ADDR_W-1:0] idx, logic [15:0] v);
         case (idx)
            vvs_pkg::CSR_LONG_PERIOD:   long_per   = v;
            vvs_pkg::CSR_MID_PERIOD:    mid_per    = v;
            vvs_pkg::CSR_SHORT_PERIOD:  short_per  = v;
            vvs_pkg::CSR_SAMPLE_PERIOD: sample_per = v;
            default: ;
         endcase
      endfunction

      function bit [3:0] knob_seconds(bit [9:0] k);
         return 4'((32'(k) * 8) / KNOB_FULL + 2);
      endfunction

      function void enter_phase(vvs_pkg::vvs_phase_type p);
         phase = p;
         counts = '0;
         period_ticks = '0;
      endfunction

      function void note_request(logic [REQ_TDATA_W-1:0] d);
         bit                   btn;
         bit [9:0]             pk;
         bit [9:0]             rk;
         int unsigned          t;
         int unsigned          per;
         int unsigned          target;
         vvs_pkg::vvs_rsp_type r;
         btn = d[0];
         pk  = d[10:1];
         rk  = d[20:11];
         r   = '0;

         if (btn && !btn_latch) begin
            run_flag  = ~run_flag;
            btn_latch = 1'b1;
         end else if (!btn && btn_latch) begin
            btn_latch = 1'b0;
         end

         // A period register of zero fires on every tick, the same as one.
         t = (32'(sample_ticks) + 1) & 32'hFFFF;
         if (t >= sample_per || t == 0) begin
            sample_ticks = '0;
            if (pk != prev_pk) begin
               press_s = knob_seconds(pk);
               r.press_changed = 1'b1;
            end
            if (rk != prev_rk) begin
               relief_s = knob_seconds(rk);
               r.relief_changed = 1'b1;
            end
            prev_pk = pk;
            prev_rk = rk;
         end else begin
            sample_ticks = t[15:0];
         end

         if (run_flag && press_s != 0 && relief_s != 0) begin
            case (phase)
               vvs_pkg::PH_OPEN: begin
                  per = mid_per; target = vvs_pkg::FIXED_COUNTS; press_open = 1'b1;
               end
               vvs_pkg::PH_PRESS: begin
                  per = long_per;  target = press_s;
               end
               vvs_pkg::PH_HOLD: begin
                  per = mid_per;   target = vvs_pkg::FIXED_COUNTS;
               end
               vvs_pkg::PH_PAUSE_A: begin
                  per = short_per; target = vvs_pkg::FIXED_COUNTS;
               end
               vvs_pkg::PH_RELIEF: begin
                  per = long_per;  target = relief_s;
               end
               vvs_pkg::PH_PAUSE_B: begin
                  per = short_per; target = vvs_pkg::FIXED_COUNTS;
               end
               default: begin
                  per = 1;         target = 0;
               end
            endcase
            if (counts >= target) begin
               case (phase)
                  vvs_pkg::PH_OPEN: begin
                     r.motor_strobe = 1'b1;
                     r.motor_code   = vvs_pkg::MOTOR_START;
                     enter_phase(vvs_pkg::PH_PRESS);
                  end
                  vvs_pkg::PH_PRESS: begin
                     r.motor_strobe = 1'b1;
                     r.motor_code   = vvs_pkg::MOTOR_STOP;
                     enter_phase(vvs_pkg::PH_HOLD);
                  end
                  vvs_pkg::PH_HOLD: begin
                     press_open = 1'b0;
                     enter_phase(vvs_pkg::PH_PAUSE_A);
                  end
                  vvs_pkg::PH_PAUSE_A: begin
                     relief_open = 1'b1;
                     enter_phase(vvs_pkg::PH_RELIEF);
                  end
                  vvs_pkg::PH_RELIEF: begin
                     relief_open = 1'b0;
                     enter_phase(vvs_pkg::PH_PAUSE_B);
                  end
                  default: enter_phase(vvs_pkg::PH_OPEN);
               endcase
            end else begin
               t = (32'(period_ticks) + 1) & 32'hFFFF;
               if (t >= per || t == 0) begin
                  period_ticks = '0;
                  if (counts < 15) counts++;
               end else begin
                  period_ticks = t[15:0];
               end
            end
         end

         r.pressure_valve = press_open;
         r.relief_valve   = relief_open;
         r.press_seconds  = press_s;
         r.relief_seconds = relief_s;
         r.running        = run_flag;
         r.phase_now      = phase;
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [vvs_pkg::RSP_TDATA_W-1:0] d);
         vvs_pkg::vvs_rsp_type got;
         vvs_pkg::vvs_rsp_type exp_r;
         string                bad;
         got = d[vvs_pkg::RSP_BITS-1:0];
         responses++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response %0d arrived with no request waiting, got 'h%05h",
                        $realtime, responses, got);
            return;
         end
         exp_r = expected_q.pop_front();
         bad = "";
         if (got.pressure_valve !== exp_r.pressure_valve) bad = {bad, " pressure_valve"};
         if (got.relief_valve   !== exp_r.relief_valve)   bad = {bad, " relief_valve"};
         if (got.motor_strobe   !== exp_r.motor_strobe)   bad = {bad, " motor_strobe"};
         if (got.motor_code     !== exp_r.motor_code)     bad = {bad, " motor_code"};
         if (got.press_seconds  !== exp_r.press_seconds)  bad = {bad, " press_seconds"};
         if (got.relief_seconds !== exp_r.relief_seconds) bad = {bad, " relief_seconds"};
         if (got.press_changed  !== exp_r.press_changed)  bad = {bad, " press_changed"};
         if (got.relief_changed !== exp_r.relief_changed) bad = {bad, " relief_changed"};
         if (got.running        !== exp_r.running)        bad = {bad, " running"};
         if (got.phase_now      !== exp_r.phase_now)      bad = {bad, " phase_now"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response %0d wrong in%s: expected 'h%05h got 'h%05h",
                        $realtime, responses, bad, exp_r, got);
         end
      endfunction
   endclass

   valve_scoreboard sb = new();

   // Generator state: the button level and knob positions held between ticks.
   bit       gen_btn = 1'b0;
   bit [9:0] gen_pk  = '0;
   bit [9:0] gen_rk  = '0;
   int       burst_left = 0;

   // Receiver side: the ready pattern rotates between always ready, coin-toss,
   // mostly ready and occasional long stalls.
   int unsigned rx_cycle   = 0;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         case ((rx_cycle / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left = stall_left - 1;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
               end
            end
         endcase
      end
   end

   // Responses are taken at the edge where valid and ready were both high;
   // the values read here are those the block saw before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_tick(bit b, bit [9:0] p, bit [9:0] r);
      return {3'b000, r, p, b};
   endfunction

   // A new knob position, with the two ends of the travel favoured.
   function automatic bit [9:0] pick_knob();
      case ($urandom_range(0, 7))
         0:       return 10'd0;
         1:       return 10'd1023;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // Mostly a well-behaved operator: the button is pressed briefly and rarely
   // while the cycle runs, sooner when stopped, and the knobs move now and
   // then. A small share of requests is pure noise.
   function automatic logic [REQ_TDATA_W-1:0] next_tick();
      if ($urandom_range(0, 99) < 8)
         return pack_tick(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)));
      if (gen_btn) begin
         if ($urandom_range(0, 1) == 0) gen_btn = 1'b0;
      end else if ($urandom_range(0, sb.run_flag ? 199 : 5) == 0) begin
         gen_btn = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) gen_pk = pick_knob();
      if ($urandom_range(0, 39) == 0) gen_rk = pick_knob();
      return pack_tick(gen_btn, gen_pk, gen_rk);
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_tick(input logic [REQ_TDATA_W-1:0] data);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(data);
   endtask

   // Between requests: bursts of random length, then a random gap with the
   // valid low. Some bursts are long, some gaps are empty.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Wait until every queued response has come and the pipeline has emptied.
   task automatic wait_idle();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [vvs_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_register(idx, v);
   endtask

   // Registers are only ever changed with the block idle.
   task automatic set_config(input logic [15:0] l, m, s, sp);
      wait_idle();
      csr_write(vvs_pkg::CSR_LONG_PERIOD, l);
      csr_write(vvs_pkg::CSR_MID_PERIOD, m);
      csr_write(vvs_pkg::CSR_SHORT_PERIOD, s);
      csr_write(vvs_pkg::CSR_SAMPLE_PERIOD, sp);
      csr_we <= 1'b0;
   endtask

   task automatic run_round(input logic [15:0] l, m, s, sp, input int n);
      set_config(l, m, s, sp);
      gen_pk = 10'($urandom_range(1, 1023));
      gen_rk = 10'($urandom_range(1, 1023));
      for (int i = 0; i < n; i++) begin
         send_tick(next_tick());
         if (i != n - 1) pace_sender();
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : main_seq
      logic [REQ_TDATA_W-1:0] directed_q[$];
      int                     failures;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two ticks at the reset periods: idle inputs, then every input bit
      // high, which sets the block running before any knob has been sampled.
      send_tick(pack_tick(1'b0, 10'd0, 10'd0));
      send_tick(pack_tick(1'b1, 10'd1023, 10'd1023));
      req_tvalid <= 1'b0;

      // Directed part with fast periods. The relief knob is first left at
      // zero, so the setting stays unset and the cycle is frozen although
      // running; then both settings are valid and the cycle starts.
      directed_q.push_back(pack_tick(1'b0, 10'd1023, 10'd0));
      directed_q.push_back(pack_tick(1'b0, 10'd1023, 10'd0));
      repeat (11) directed_q.push_back(pack_tick(1'b0, 10'd1023, 10'd1));
      // Deep in the pressurize phase the target drops below the count
      // already reached, so the phase ends on that same tick.
      directed_q.push_back(pack_tick(1'b0, 10'd1, 10'd1));
      // The mapping steps from two to three seconds between 127 and 128.
      directed_q.push_back(pack_tick(1'b0, 10'd127, 10'd1));
      directed_q.push_back(pack_tick(1'b0, 10'd128, 10'd1));
      // Stop, stay frozen for a tick, start again.
      directed_q.push_back(pack_tick(1'b1, 10'd128, 10'd1));
      directed_q.push_back(pack_tick(1'b0, 10'd128, 10'd1));
      directed_q.push_back(pack_tick(1'b1, 10'd128, 10'd1));
      // A knob returned to zero after a change is still evaluated.
      directed_q.push_back(pack_tick(1'b0, 10'd0, 10'd1023));

      set_config(16'd2, 16'd1, 16'd1, 16'd1);
      foreach (directed_q[i]) begin
         send_tick(directed_q[i]);
         if (i != directed_q.size() - 1) pace_sender();
      end
      req_tvalid <= 1'b0;

      // Random part: most rounds use short periods so that the cycle turns
      // over many times; the extremes get a few ticks each.
      run_round(16'd1, 16'd1, 16'd1, 16'd1, 300);
      run_round(16'd0, 16'd0, 16'd0, 16'd0, 250);
      run_round(16'd2, 16'd1, 16'd1, 16'd3, 300);
      run_round(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
      run_round(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 300);
      run_round(16'd1, 16'd1, 16'd1, 16'hFFFF, 60);
      run_round(16'hFFFF, 16'd1, 16'd1, 16'd1, 60);
      run_round(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 300);
      run_round(16'd4, 16'd2, 16'd2, 16'd8, 240);

      // Drain, with a bound so that a lost response is reported.
      for (int k = 0; k < 5000 && sb.expected_q.size() != 0; k++) @(posedge clock);
      repeat (5) @(posedge clock);

      if (sb.expected_q.size() != 0)
         $display("%0t: %0d expected responses never arrived",
                  $realtime, sb.expected_q.size());
      failures = sb.mismatches + sb.expected_q.size();
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Generous bound on the whole run: far beyond the slowest legal pacing.
   initial begin : watchdog
      #5_000_000;
      $display("%0t: run timed out", $realtime);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: ventilator_valve_sequencer.f
rtl/vvs_pkg.sv
rtl/vvs_core.sv
rtl/ventilator_valve_sequencer.sv
test/testbench.sv
